@@ rtl/bmua_pkg.sv @@
package bmua_pkg;

  localparam int unsigned ADDR_W = 13;
  localparam int unsigned OFF_W  = 3;
  localparam int unsigned BLK_W  = ADDR_W - OFF_W;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned MEM_W  = DATA_W + 1;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned ST_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_READ_WORD  = 2'd0,
    OP_READ_BYTE  = 2'd1,
    OP_WRITE_WORD = 2'd2,
    OP_WRITE_BYTE = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    STATUS_OK         = 2'd0,
    STATUS_INVALID    = 2'd1,
    STATUS_MISALIGNED = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_LO,
    S_HI
  } state_e;

  typedef enum logic [2:0] {
    RES_INVALID,
    RES_MISALIGNED,
    RES_OK_ZERO,
    RES_WORD_LO,
    RES_WORD_JOIN,
    RES_BYTE
  } res_e;

  typedef struct packed {
    logic load;
    logic clr_wr;
    logic rd_lo;
    logic rd_hi;
    logic wr_en;
    logic post;
    res_e res;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic oob;
    logic next_oob;
    logic unaligned;
    logic rd_valid;
    logic out_free;
    logic clr_last;
  } sts_t;

endpackage

@@ rtl/block_memory_unaligned_access.sv @@
// Channel   Handshake               Payload
// in        in_valid_i/in_ready_o   op_i, byte_address_i, write_data_i
// out       out_valid_o/out_ready_i read_data_o, status_o
//
// A word write, aligned or misaligned, or an out of range block is answered from the
// decode state; a byte read, a byte write, an aligned word read, or a word read refused
// at its first block or at the memory end passes the low read state; an unaligned word
// read of two blocks passes the high state too, as the single read port reads in turn.
// After reset a clearing pass writes every block to reset the valid marks before
// the first access is taken. A full result register holds the access until taken.
module block_memory_unaligned_access #(
  parameter int unsigned NUM_BLOCKS = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [bmua_pkg::OP_W-1:0]   op_i,
  input  logic [bmua_pkg::ADDR_W-1:0] byte_address_i,
  input  logic [bmua_pkg::DATA_W-1:0] write_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bmua_pkg::DATA_W-1:0] read_data_o,
  output logic [bmua_pkg::ST_W-1:0]   status_o
);
  import bmua_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bmua_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bmua_dp #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op_i),
    .byte_address_i (byte_address_i),
    .write_data_i   (write_data_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .read_data_o    (read_data_o),
    .status_o       (status_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule

@@ rtl/bmua_ram.sv @@
module bmua_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 65
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/bmua_ctrl.sv @@
module bmua_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bmua_pkg::sts_t sts_i,
  output bmua_pkg::cmd_t cmd_o
);
  import bmua_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (!sts_i.oob && sts_i.op != OP_WRITE_WORD) begin
          state_d = S_LO;
        end else if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      S_LO: begin
        if (sts_i.rd_valid && sts_i.op == OP_READ_WORD && sts_i.unaligned
            && !sts_i.next_oob) begin
          state_d = S_HI;
        end else if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      S_HI: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.res  = RES_INVALID;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_DECODE: begin
        if (sts_i.oob) begin
          cmd_o.post = sts_i.out_free;
          cmd_o.res  = RES_INVALID;
        end else if (sts_i.op == OP_WRITE_WORD) begin
          cmd_o.post = sts_i.out_free;
          if (sts_i.unaligned) begin
            cmd_o.res = RES_MISALIGNED;
          end else begin
            cmd_o.res   = RES_OK_ZERO;
            cmd_o.wr_en = sts_i.out_free;
          end
        end else begin
          cmd_o.rd_lo = 1'b1;
        end
      end
      S_LO: begin
        if (!sts_i.rd_valid && sts_i.op != OP_WRITE_BYTE) begin
          cmd_o.post = sts_i.out_free;
          cmd_o.res  = RES_INVALID;
        end else begin
          unique case (sts_i.op)
            OP_READ_BYTE: begin
              cmd_o.post = sts_i.out_free;
              cmd_o.res  = RES_BYTE;
            end
            OP_WRITE_BYTE, OP_WRITE_WORD: begin
              cmd_o.post  = sts_i.out_free;
              cmd_o.wr_en = sts_i.out_free;
              cmd_o.res   = RES_OK_ZERO;
            end
            OP_READ_WORD: begin
              if (!sts_i.unaligned) begin
                cmd_o.post = sts_i.out_free;
                cmd_o.res  = RES_WORD_LO;
              end else if (sts_i.next_oob) begin
                cmd_o.post = sts_i.out_free;
                cmd_o.res  = RES_INVALID;
              end else begin
                cmd_o.rd_hi = 1'b1;
              end
            end
            default: cmd_o.res = RES_INVALID;
          endcase
        end
      end
      S_HI: begin
        cmd_o.post = sts_i.out_free;
        cmd_o.res  = sts_i.rd_valid ? RES_WORD_JOIN : RES_INVALID;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

@@ rtl/bmua_dp.sv @@
module bmua_dp #(
  parameter int unsigned NUM_BLOCKS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [bmua_pkg::OP_W-1:0]     op_i,
  input  logic [bmua_pkg::ADDR_W-1:0]   byte_address_i,
  input  logic [bmua_pkg::DATA_W-1:0]   write_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bmua_pkg::DATA_W-1:0]   read_data_o,
  output logic [bmua_pkg::ST_W-1:0]     status_o,
  input  bmua_pkg::cmd_t                cmd_i,
  output bmua_pkg::sts_t                sts_o
);
  import bmua_pkg::*;

  localparam int unsigned IdxW = (NUM_BLOCKS > 2) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned CmpW = ((IdxW > BLK_W) ? IdxW : BLK_W) + 1;
  localparam logic [CmpW-1:0] NumBlk = CmpW'(NUM_BLOCKS);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_BLOCKS - 1);

  op_e                op_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [DATA_W-1:0]  wdata_q;
  logic [DATA_W-1:0]  lo_q;
  logic [IdxW-1:0]    cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic [DATA_W-1:0]  read_data_q;
  logic [ST_W-1:0]    status_q;

  logic [OFF_W-1:0]   off;
  logic [CmpW-1:0]    blk_ext;
  logic [CmpW-1:0]    nxt_ext;
  logic [IdxW-1:0]    blk_idx;
  logic [IdxW-1:0]    nxt_idx;
  logic [MEM_W-1:0]   rdata;
  logic [DATA_W-1:0]  cur_data;
  logic [DATA_W-1:0]  base;
  logic [DATA_W-1:0]  merged;
  logic [DATA_W-1:0]  lane_sel;
  logic [2*DATA_W-1:0] joined;
  logic [5:0]         sh;
  logic               we;
  logic [IdxW-1:0]    waddr;
  logic [MEM_W-1:0]   wdata;
  logic [IdxW-1:0]    raddr;
  logic [DATA_W-1:0]  res_data;
  logic [ST_W-1:0]    res_status;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_e'(op_i);
      addr_q  <= byte_address_i;
      wdata_q <= write_data_i;
    end
    if (cmd_i.rd_hi) begin
      lo_q <= cur_data;
    end
    if (cmd_i.post) begin
      read_data_q <= res_data;
      status_q    <= res_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cnt_d       = cmd_i.clr_wr ? cnt_q + IdxW'(1) : cnt_q;
  assign out_valid_d = cmd_i.post ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  assign off     = addr_q[OFF_W-1:0];
  assign blk_ext = CmpW'(addr_q[ADDR_W-1:OFF_W]);
  assign nxt_ext = blk_ext + CmpW'(1);
  assign blk_idx = blk_ext[IdxW-1:0];
  assign nxt_idx = nxt_ext[IdxW-1:0];
  assign sh      = {off, 3'b000};

  assign cur_data  = rdata[DATA_W-1:0];
  assign base      = rdata[DATA_W] ? cur_data : '0;
  assign lane_sel  = DATA_W'({BYTE_W{1'b1}}) << sh;
  assign merged    = (base & ~lane_sel) | (DATA_W'(wdata_q[BYTE_W-1:0]) << sh);
  assign joined    = {cur_data, lo_q} >> sh;

  always_comb begin
    we    = cmd_i.clr_wr | cmd_i.wr_en;
    waddr = cmd_i.clr_wr ? cnt_q : blk_idx;
    if (cmd_i.clr_wr) begin
      wdata = '0;
    end else if (op_q == OP_WRITE_WORD) begin
      wdata = {1'b1, wdata_q};
    end else begin
      wdata = {1'b1, merged};
    end
    raddr = cmd_i.rd_hi ? nxt_idx : blk_idx;
  end

  bmua_ram #(
    .DEPTH (NUM_BLOCKS),
    .WIDTH (MEM_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_lo | cmd_i.rd_hi),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    res_data   = '0;
    res_status = STATUS_OK;
    unique case (cmd_i.res)
      RES_INVALID:    res_status = STATUS_INVALID;
      RES_MISALIGNED: res_status = STATUS_MISALIGNED;
      RES_OK_ZERO:    res_status = STATUS_OK;
      RES_WORD_LO:    res_data   = cur_data;
      RES_WORD_JOIN:  res_data   = joined[DATA_W-1:0];
      RES_BYTE:       res_data   = DATA_W'(8'(cur_data >> sh));
      default:        res_status = STATUS_INVALID;
    endcase
  end

  always_comb begin
    sts_o.op        = op_q;
    sts_o.oob       = blk_ext >= NumBlk;
    sts_o.next_oob  = nxt_ext >= NumBlk;
    sts_o.unaligned = off != '0;
    sts_o.rd_valid  = rdata[DATA_W];
    sts_o.out_free  = !out_valid_q || out_ready_i;
    sts_o.clr_last  = cnt_q == LastIdx;
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;
  assign status_o    = status_q;

endmodule

@@ sim/block_memory_unaligned_access_tb.sv @@
`timescale 1ns / 1ps

module block_memory_unaligned_access_tb;
  import bmua_pkg::*;

  localparam int unsigned NUM_BLOCKS   = 1024;
  localparam int unsigned WIN_BLOCKS   = 16;
  localparam int unsigned PHASE_ITEMS  = 375;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  class data_memory_scoreboard;
    logic [DATA_W-1:0] block_data [NUM_BLOCKS];
    bit                block_valid [NUM_BLOCKS];
    logic [DATA_W-1:0] exp_data_q [$];
    status_e           exp_status_q [$];
    int unsigned       errors;
    int unsigned       accesses;
    int unsigned       results;
    int unsigned       op_count [4];
    int unsigned       status_count [4];

    function void note_access(op_e op, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] wdata);
      int unsigned       blk;
      int unsigned       off;
      int unsigned       nxt;
      logic [DATA_W-1:0] data;
      status_e           st;
      blk  = addr[ADDR_W-1:OFF_W];
      off  = addr[OFF_W-1:0];
      nxt  = blk + 1;
      data = '0;
      st   = STATUS_OK;
      accesses++;
      op_count[op]++;
      if (blk >= NUM_BLOCKS) begin
        st = STATUS_INVALID;
      end else begin
        case (op)
          OP_READ_WORD: begin
            if (!block_valid[blk]) begin
              st = STATUS_INVALID;
            end else if (off == 0) begin
              data = block_data[blk];
            end else if (nxt >= NUM_BLOCKS || !block_valid[nxt]) begin
              st = STATUS_INVALID;
            end else begin
              data = (block_data[blk] >> (8 * off)) | (block_data[nxt] << (64 - 8 * off));
            end
          end
          OP_READ_BYTE: begin
            if (!block_valid[blk]) begin
              st = STATUS_INVALID;
            end else begin
              data[BYTE_W-1:0] = block_data[blk][8*off +: 8];
            end
          end
          OP_WRITE_WORD: begin
            if (off != 0) begin
              st = STATUS_MISALIGNED;
            end else begin
              block_data[blk]  = wdata;
              block_valid[blk] = 1'b1;
            end
          end
          default: begin
            if (!block_valid[blk]) begin
              block_data[blk]  = '0;
              block_valid[blk] = 1'b1;
            end
            block_data[blk][8*off +: 8] = wdata[BYTE_W-1:0];
          end
        endcase
      end
      exp_data_q   = {exp_data_q, data};
      exp_status_q = {exp_status_q, st};
    endfunction

    function void check_result(logic [DATA_W-1:0] rdata, logic [ST_W-1:0] st);
      logic [DATA_W-1:0] exp_data;
      status_e           exp_status;
      if (exp_data_q.size() == 0) begin
        $error("result beat with no access pending: read_data %h status %0d", rdata, st);
        errors++;
        return;
      end
      exp_data   = exp_data_q.pop_front();
      exp_status = exp_status_q.pop_front();
      results++;
      status_count[st]++;
      if (rdata !== exp_data) begin
        $error("read_data mismatch: expected %h, actual %h", exp_data, rdata);
        errors++;
      end
      if (st !== exp_status) begin
        $error("status mismatch: expected %0d, actual %0d", exp_status, st);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return exp_data_q.size();
    endfunction
  endclass

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic [OP_W-1:0]     op_i           = '0;
  logic [ADDR_W-1:0]   byte_address_i = '0;
  logic [DATA_W-1:0]   write_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i    = 1'b0;
  logic [DATA_W-1:0]   read_data_o;
  logic [ST_W-1:0]     status_o;

  data_memory_scoreboard sb = new;
  int unsigned           sender_idle_pct = 0;
  int unsigned           receiver_stall_pct = 0;
  int unsigned           window_base = 0;
  int unsigned           cycles = 0;

  block_memory_unaligned_access #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .byte_address_i(byte_address_i),
    .write_data_i  (write_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .read_data_o   (read_data_o),
    .status_o      (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycles, sb.pending());
      $display("block_memory_unaligned_access test failed");
      $finish;
    end
  end

  // check the result beat, then pick the next ready
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(read_data_o, status_o);
    end
    out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  task automatic send_access(input op_e op, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] wdata);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= op;
    byte_address_i <= addr;
    write_data_i   <= wdata;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_access(op, addr, wdata);
  endtask

  task automatic send_random_access();
    op_e               op;
    int unsigned       blk;
    int unsigned       off;
    int unsigned       pick;
    logic [DATA_W-1:0] wdata;
    op   = op_e'($urandom_range(3));
    pick = $urandom_range(99);
    if (pick < 75) begin
      blk = window_base + $urandom_range(WIN_BLOCKS - 1);
    end else if (pick < 85) begin
      blk = $urandom_range(NUM_BLOCKS - 1, NUM_BLOCKS - 8);
    end else begin
      blk = $urandom_range(NUM_BLOCKS - 1);
    end
    off = $urandom_range(7);
    // mostly aligned word writes so that blocks fill up
    if (op == OP_WRITE_WORD && $urandom_range(99) < 70) off = 0;
    pick = $urandom_range(9);
    if (pick == 0) wdata = '1;
    else if (pick == 1) wdata = '0;
    else wdata = {$urandom(), $urandom()};
    send_access(op, ADDR_W'(blk * 8 + off), wdata);
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    window_base        = $urandom_range(NUM_BLOCKS - WIN_BLOCKS);
    repeat (PHASE_ITEMS) send_random_access();
  endtask

  task automatic send_directed();
    send_access(OP_READ_WORD, 13'd0, '0);
    send_access(OP_READ_BYTE, 13'd5, '0);
    send_access(OP_WRITE_WORD, 13'd3, 64'h0123_4567_89ab_cdef);
    send_access(OP_READ_WORD, 13'd0, '0);
    send_access(OP_WRITE_WORD, 13'd0, '1);
    send_access(OP_READ_WORD, 13'd0, '0);
    send_access(OP_READ_WORD, 13'd1, '0);
    send_access(OP_WRITE_BYTE, 13'd13, 64'hffff_ffff_ffff_ffa5);
    for (int k = 1; k < 8; k++) send_access(OP_READ_WORD, ADDR_W'(k), '0);
    send_access(OP_READ_BYTE, 13'd8, '0);
    send_access(OP_READ_BYTE, 13'd13, '0);
    send_access(OP_WRITE_WORD, 13'd8184, '0);
    send_access(OP_WRITE_BYTE, 13'd8191, '1);
    send_access(OP_READ_WORD, 13'd8185, '0);
    send_access(OP_READ_WORD, 13'd8184, '0);
    send_access(OP_READ_BYTE, 13'd8191, '0);
    send_access(OP_WRITE_WORD, 13'd16, 64'h0123_4567_89ab_cdef);
    send_access(OP_WRITE_BYTE, 13'd16, 64'h5a);
    send_access(OP_READ_WORD, 13'd16, '0);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_directed();
    run_phase(0, 0);
    run_phase(54, 0);
    run_phase(0, 54);
    run_phase(9, 9);
    in_valid_i         <= 1'b0;
    receiver_stall_pct = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d accesses: %0d word reads, %0d byte reads, %0d word writes, %0d byte writes",
             sb.accesses, sb.op_count[OP_READ_WORD], sb.op_count[OP_READ_BYTE],
             sb.op_count[OP_WRITE_WORD], sb.op_count[OP_WRITE_BYTE]);
    $display("%0d results checked: %0d ok, %0d invalid, %0d misaligned; %0d errors",
             sb.results, sb.status_count[STATUS_OK], sb.status_count[STATUS_INVALID],
             sb.status_count[STATUS_MISALIGNED], sb.errors);
    if (sb.errors == 0) begin
      $display("block_memory_unaligned_access test passed");
    end else begin
      $display("block_memory_unaligned_access test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/bmua_pkg.sv
rtl/bmua_ram.sv
rtl/bmua_ctrl.sv
rtl/bmua_dp.sv
rtl/block_memory_unaligned_access.sv
sim/block_memory_unaligned_access_tb.sv
